// ===== rtl/core/tvt_pkg.sv =====
// Shared types and constants for the touch velocity tracker.
`timescale 1ns / 1ps
`default_nettype none
package tvt_pkg;

  // Item mode codes
  localparam logic [2:0] MODE_DOWN   = 3'd0;
  localparam logic [2:0] MODE_MOVE   = 3'd1;
  localparam logic [2:0] MODE_UP     = 3'd2;
  localparam logic [2:0] MODE_CANCEL = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;
  localparam logic [2:0] MODE_RESET  = 3'd5;

  // Register byte address of deceleration
  localparam logic [2:0] ADDR_DECEL = 3'd0;
  localparam logic [15:0] DECEL_RESET = 16'd3000;

  // Divider width, rate scale (ms to s), fling noise floor in Q4 px/s
  localparam int DIV_W = 64;
  localparam logic [9:0] RATE_SCALE = 10'd1000;
  localparam logic [31:0] NOISE_FLOOR_Q4 = 32'd160;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE,
    ST_Q_CUR,
    ST_Q_ISSUE,
    ST_Q_PREV,
    ST_Q_IDIV,
    ST_Q_NEXT,
    ST_Q_VDIV,
    ST_Q_VWAIT,
    ST_Q_FL,
    ST_Q_FDIV,
    ST_Q_FWAIT,
    ST_Q_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic rd_off0;
    logic latch_in;
    logic do_down;
    logic do_move;
    logic do_end;
    logic do_reset;
    logic q_init;
    logic lat_cur;
    logic chk;
    logic acc;
    logic nxt;
    logic vdiv;
    logic vlat;
    logic sq;
    logic fdiv;
    logic flat;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic n_lt2;
    logic dt_pos;
    logic last_int;
    logic wsum_zero;
    logic fl_skip;
    logic div_done;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/touch_velocity_tracker_top.sv =====
// Touch velocity tracker: down, up, cancel and reset are handled in the idle state, a move
// also passes through the move state. A query walks up to MAX_INTERVALS intervals; each
// one with positive dt runs a 64-step divide, then one divide for the mean and one for the
// fling, each skipped when it has no work, all on the single shared serial divider. The
// result word sits in an output register, so the next item is taken while it waits.
// Synchronous reset clears tracking state; deceleration returns to 3000. Ring contents are
// not cleared.
`timescale 1ns / 1ps
`default_nettype none
module touch_velocity_tracker_top
  import tvt_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16,
  parameter int MAX_INTERVALS = 5
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         mode,
  input  wire logic [7:0]         pointer_id,
  input  wire logic signed [19:0] pos_y,
  input  wire logic [31:0]        time_ms,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      scroll_delta,
  output logic signed [31:0]      velocity,
  output logic signed [31:0]      fling_distance
);

  logic [15:0] decel;
  cmd_t        cmd;
  sts_t        sts;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_DECEL) ? {16'h0000, decel} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      decel <= DECEL_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      decel <= pwdata[15:0];
    end
  end

  tvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  tvt_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .pointer_id     (pointer_id),
    .pos_y          (pos_y),
    .time_ms        (time_ms),
    .decel          (decel),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .scroll_delta   (scroll_delta),
    .velocity       (velocity),
    .fling_distance (fling_distance)
  );

  // Checks
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result word overwrote a pending word");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    ((cmd.chk && sts.dt_pos) || cmd.vdiv || cmd.fdiv) |-> !sts.div_busy)
    else $error("divider started while busy");

endmodule
`default_nettype wire

// ===== rtl/core/tvt_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tvt_div
  import tvt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] num,
  input  wire logic [DIV_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic [DIV_W-1:0]      quo
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] den_l;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] trial;

  // Trial subtract of the shifted remainder
  assign shifted = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_l};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= num;
        den_l <= den;
        rem   <= '0;
        cnt   <= CNT_W'(DIV_W);
        busy  <= 1'b1;
      end else if (busy) begin
        if (!trial[DIV_W+1]) begin
          rem <= trial[DIV_W:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tvt_datapath.sv =====
// Datapath: history ring, accumulators, velocity and fling arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module tvt_datapath
  import tvt_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16,
  parameter int MAX_INTERVALS = 5
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [7:0]         pointer_id,
  input  wire logic signed [19:0] pos_y,
  input  wire logic [31:0]        time_ms,
  input  wire logic [15:0]        decel,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic signed [31:0]      scroll_delta,
  output logic signed [31:0]      velocity,
  output logic signed [31:0]      fling_distance
);

  localparam int HW  = $clog2(HISTORY_DEPTH);
  localparam int CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int AW  = HW + 1;
  localparam int IW  = $clog2(MAX_INTERVALS + 1);
  localparam int VSW = 34 + MAX_INTERVALS;

  // Ring memory and registered read port
  logic signed [19:0] pos_mem  [HISTORY_DEPTH];
  logic [31:0]        time_mem [HISTORY_DEPTH];
  logic signed [19:0] rd_pos;
  logic [31:0]        rd_time;

  logic [HW-1:0] head;
  logic [CW-1:0] count;
  logic          active;
  logic [7:0]    tpid;
  logic signed [31:0] accum;

  logic [7:0]         in_pid;
  logic signed [19:0] in_pos;
  logic [31:0]        in_time;

  logic signed [19:0] cur_pos;
  logic [31:0]        cur_time;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      used;
  logic signed [VSW-1:0] vsum;
  logic [MAX_INTERVALS-1:0] wsum;
  logic               ineg;
  logic signed [31:0] vel;
  logic signed [31:0] fling;
  logic [63:0]        sq;

  // Read address: newest entry minus offset
  logic [IW:0]   off1;
  logic [AW-1:0] adiff;
  logic [HW-1:0] rd_addr;

  always_comb begin
    off1 = cmd.rd_off0 ? (IW+1)'(1) : ({1'b0, idx} + (IW+1)'(2));
    adiff = AW'(head) - AW'(off1);
    if (adiff[AW-1]) rd_addr = HW'(adiff + AW'(HISTORY_DEPTH));
    else rd_addr = HW'(adiff);
  end

  // Write port
  logic               move_ok;
  logic               wr_en;
  logic [HW-1:0]      wr_addr;
  logic signed [19:0] wr_pos;
  logic [31:0]        wr_time;
  logic [HW-1:0]      head_inc;

  assign move_ok  = active && (tpid == in_pid);
  assign wr_en    = cmd.do_down || (cmd.do_move && move_ok);
  assign wr_addr  = cmd.do_down ? '0 : head;
  assign wr_pos   = cmd.do_down ? pos_y : in_pos;
  assign wr_time  = cmd.do_down ? time_ms : in_time;
  assign head_inc = (head == HW'(HISTORY_DEPTH - 1)) ? '0 : head + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr]  <= wr_pos;
      time_mem[wr_addr] <= wr_time;
    end
    rd_pos  <= pos_mem[rd_addr];
    rd_time <= time_mem[rd_addr];
  end

  // Move delta, saturating
  logic signed [20:0] mdy;
  logic signed [32:0] msum;
  logic signed [31:0] msat;

  always_comb begin
    mdy  = 21'(in_pos) - 21'(rd_pos);
    msum = 33'(accum) + 33'(mdy);
    if (msum > 33'sd2147483647) msat = 32'sh7fffffff;
    else if (msum < -33'sd2147483648) msat = 32'sh80000000;
    else msat = msum[31:0];
  end

  // Shared divider signals
  logic             div_start;
  logic [DIV_W-1:0] div_num;
  logic [DIV_W-1:0] div_den;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  // Interval terms
  logic [31:0]        dt;
  logic signed [20:0] idy;
  logic [20:0]        idy_mag;
  logic [30:0]        iscaled;
  logic [MAX_INTERVALS-1:0] nints;
  logic [IW-1:0]      shamt;
  logic [VSW-1:0]     term;
  logic [VSW-1:0]     vmag_sum;
  logic [31:0]        vmag;
  logic [20:0]        den32;

  always_comb begin
    dt      = cur_time - rd_time;
    idy     = 21'(cur_pos) - 21'(rd_pos);
    idy_mag = idy[20] ? 21'(-idy) : 21'(idy);
    iscaled = 31'(idy_mag) * 31'(RATE_SCALE);
    if (count - 1'b1 < CW'(MAX_INTERVALS)) nints = MAX_INTERVALS'(count - 1'b1);
    else nints = MAX_INTERVALS'(MAX_INTERVALS);
    shamt    = IW'(MAX_INTERVALS - 1) - used;
    term     = VSW'(div_quo[31:0]) << shamt;
    vmag_sum = vsum[VSW-1] ? VSW'(-vsum) : VSW'(vsum);
    vmag     = vel[31] ? 32'(-vel) : 32'(vel);
    den32    = {decel, 5'b00000};
  end

  // Shared divider
  always_comb begin
    div_start = (cmd.chk && sts.dt_pos) || cmd.vdiv || cmd.fdiv;
    if (cmd.vdiv) begin
      div_num = DIV_W'(vmag_sum) + DIV_W'(wsum >> 1);
      div_den = DIV_W'(wsum);
    end else if (cmd.fdiv) begin
      div_num = sq + DIV_W'(den32 >> 1);
      div_den = DIV_W'(den32);
    end else begin
      div_num = DIV_W'(iscaled) + DIV_W'(dt >> 1);
      div_den = DIV_W'(dt);
    end
  end

  tvt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Status to controller
  always_comb begin
    sts.n_lt2     = count < CW'(2);
    sts.dt_pos    = !dt[31] && (dt != '0);
    sts.last_int  = (MAX_INTERVALS'(idx) + 1'b1) >= nints;
    sts.wsum_zero = (wsum == '0);
    sts.fl_skip   = (decel == '0) || (vmag < NOISE_FLOOR_Q4);
    sts.div_done  = div_done;
    sts.div_busy  = div_busy;
    sts.out_free  = !out_valid || !out_stall;
  end

  // Tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      active <= 1'b0;
      tpid   <= '0;
      accum  <= '0;
    end else begin
      if (cmd.do_down) begin
        tpid   <= pointer_id;
        active <= 1'b1;
        accum  <= '0;
        head   <= HW'(1);
        count  <= CW'(1);
      end
      if (cmd.do_move && move_ok) begin
        if (count != '0) accum <= msat;
        head <= head_inc;
        if (count < CW'(HISTORY_DEPTH)) count <= count + 1'b1;
      end
      if (cmd.do_end) begin
        active <= 1'b0;
        accum  <= '0;
      end
      if (cmd.do_reset) begin
        active <= 1'b0;
        tpid   <= '0;
        head   <= '0;
        count  <= '0;
        accum  <= '0;
      end
      if (cmd.out_load) accum <= '0;
    end
  end

  // Query working registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_pid  <= pointer_id;
      in_pos  <= pos_y;
      in_time <= time_ms;
    end
    if (cmd.q_init) begin
      idx   <= '0;
      used  <= '0;
      vsum  <= '0;
      wsum  <= '0;
      vel   <= '0;
      fling <= '0;
    end
    if (cmd.lat_cur || cmd.nxt) begin
      cur_pos  <= rd_pos;
      cur_time <= rd_time;
    end
    if (cmd.nxt) idx <= idx + 1'b1;
    if (cmd.chk) ineg <= idy[20];
    if (cmd.acc) begin
      vsum <= ineg ? vsum - $signed(term) : vsum + $signed(term);
      wsum <= wsum + (MAX_INTERVALS'(1) << shamt);
      used <= used + 1'b1;
    end
    if (cmd.vlat) begin
      if (!vsum[VSW-1]) begin
        if (div_quo > DIV_W'(32'h7fffffff)) vel <= 32'sh7fffffff;
        else vel <= div_quo[31:0];
      end else begin
        if (div_quo > DIV_W'(32'h80000000)) vel <= 32'sh80000000;
        else vel <= 32'(-div_quo[31:0]);
      end
    end
    if (cmd.sq) sq <= 64'(vmag) * 64'(vmag);
    if (cmd.flat) begin
      if (div_quo > DIV_W'(32'h7fffffff))
        fling <= vel[31] ? -32'sh7fffffff : 32'sh7fffffff;
      else
        fling <= vel[31] ? 32'(-div_quo[31:0]) : div_quo[31:0];
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      scroll_delta   <= accum;
      velocity       <= vel;
      fling_distance <= fling;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tvt_ctrl.sv =====
// Controller: sequences item handling and the query computation.
`timescale 1ns / 1ps
`default_nettype none
module tvt_ctrl
  import tvt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [2:0] mode,
  input  wire sts_t       sts,
  output logic            in_stall,
  output cmd_t            cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.rd_off0 = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          unique case (mode) inside
            MODE_DOWN: cmd.do_down = 1'b1;
            MODE_MOVE: state_next = ST_MOVE;
            MODE_UP, MODE_CANCEL: cmd.do_end = 1'b1;
            MODE_QUERY: begin
              cmd.q_init = 1'b1;
              state_next = sts.n_lt2 ? ST_Q_VDIV : ST_Q_CUR;
            end
            MODE_RESET: cmd.do_reset = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MOVE: begin
        cmd.do_move = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_Q_CUR: begin
        cmd.lat_cur = 1'b1;
        state_next  = ST_Q_PREV;
      end
      ST_Q_ISSUE: state_next = ST_Q_PREV;
      ST_Q_PREV: begin
        cmd.chk    = 1'b1;
        state_next = sts.dt_pos ? ST_Q_IDIV : ST_Q_NEXT;
      end
      ST_Q_IDIV: begin
        if (sts.div_done) begin
          cmd.acc    = 1'b1;
          state_next = ST_Q_NEXT;
        end
      end
      ST_Q_NEXT: begin
        cmd.nxt    = 1'b1;
        state_next = sts.last_int ? ST_Q_VDIV : ST_Q_ISSUE;
      end
      ST_Q_VDIV: begin
        if (sts.wsum_zero) begin
          state_next = ST_Q_FL;
        end else begin
          cmd.vdiv   = 1'b1;
          state_next = ST_Q_VWAIT;
        end
      end
      ST_Q_VWAIT: begin
        if (sts.div_done) begin
          cmd.vlat   = 1'b1;
          state_next = ST_Q_FL;
        end
      end
      ST_Q_FL: begin
        if (sts.fl_skip) begin
          state_next = ST_Q_DONE;
        end else begin
          cmd.sq     = 1'b1;
          state_next = ST_Q_FDIV;
        end
      end
      ST_Q_FDIV: begin
        cmd.fdiv   = 1'b1;
        state_next = ST_Q_FWAIT;
      end
      ST_Q_FWAIT: begin
        if (sts.div_done) begin
          cmd.flat   = 1'b1;
          state_next = ST_Q_DONE;
        end
      end
      ST_Q_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/tb_touch_velocity_tracker_top.sv =====
// Testbench for the touch velocity tracker: directed and random touch streams checked
// against an in-bench tracker model.
`timescale 1ns / 1ps
`default_nettype none
module tb_touch_velocity_tracker_top
  import tvt_pkg::*;
();

  localparam int DEPTH = 16;
  localparam int NUM_INT = 5;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic signed [31:0] delta;
    logic signed [31:0] vel;
    logic signed [31:0] fling;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] mode = '0;
  logic [7:0] pointer_id = '0;
  logic signed [19:0] pos_y = '0;
  logic [31:0] time_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] scroll_delta, velocity, fling_distance;

  always #4 clk = ~clk;

  touch_velocity_tracker_top dut (.*);

  // Tracker state copy
  logic signed [19:0] y_hist [DEPTH];
  logic [31:0] t_hist [DEPTH];
  int unsigned head, count;
  bit active;
  logic [7:0] owner;
  logic signed [31:0] scroll_sum;
  logic [15:0] decel;

  result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_rx = 1'b0;
  bit gaps_on = 1'b1;
  logic [31:0] now_ms = 32'd1000;
  logic [7:0] cur_ptr = 8'd3;
  logic signed [19:0] cur_y = '0;

  function automatic logic signed [63:0] round_div(logic signed [63:0] num,
                                                   logic signed [63:0] den);
    logic [63:0] mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int unsigned slot_back(int unsigned off);
    return (head + DEPTH - 1 - off) % DEPTH;
  endfunction

  function automatic void store_sample(logic signed [19:0] y, logic [31:0] t);
    y_hist[head] = y;
    t_hist[head] = t;
    head = (head + 1) % DEPTH;
    if (count < DEPTH) count++;
  endfunction

  function automatic logic signed [31:0] track_velocity();
    int unsigned nint, used;
    logic signed [63:0] vsum, wsum, dt, dy, v;
    logic [31:0] d;
    vsum = 0; wsum = 0; used = 0;
    if (count < 2) return 0;
    nint = (count - 1 < NUM_INT) ? count - 1 : NUM_INT;
    for (int i = 0; i < nint; i++) begin
      d = t_hist[slot_back(i)] - t_hist[slot_back(i + 1)];
      dt = $signed(d);
      if (dt <= 0) continue;
      dy = y_hist[slot_back(i)] - y_hist[slot_back(i + 1)];
      v = round_div(1000 * dy, dt);
      vsum += (64'sd1 << (NUM_INT - 1 - used)) * v;
      wsum += 64'sd1 << (NUM_INT - 1 - used);
      used++;
    end
    if (wsum == 0) return 0;
    return clamp32(round_div(vsum, wsum));
  endfunction

  function automatic logic signed [31:0] fling_for(logic signed [31:0] v);
    logic [63:0] mag, den, q;
    if (decel == 0) return 0;
    mag = v < 0 ? -64'(v) : 64'(v);
    if (mag < 160) return 0;
    den = 32 * 64'(decel);
    q = (mag * mag + den / 2) / den;
    if (q > 64'd2147483647) q = 64'd2147483647;
    return v < 0 ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

  // Apply one accepted word to the model
  function automatic void track_word(logic [2:0] m, logic [7:0] pid,
                                     logic signed [19:0] y, logic [31:0] t);
    result_t r;
    case (m)
      MODE_DOWN: begin
        owner = pid; active = 1; head = 0; count = 0; scroll_sum = 0;
        store_sample(y, t);
      end
      MODE_MOVE: begin
        if (active && owner == pid) begin
          if (count > 0)
            scroll_sum = clamp32(64'(scroll_sum) + 64'(y) - 64'(y_hist[slot_back(0)]));
          store_sample(y, t);
        end
      end
      MODE_UP, MODE_CANCEL: begin
        active = 0; scroll_sum = 0;
      end
      MODE_QUERY: begin
        r.delta = scroll_sum;
        r.vel = track_velocity();
        r.fling = fling_for(r.vel);
        pending_results.push_back(r);
        scroll_sum = 0;
      end
      MODE_RESET: begin
        active = 0; owner = 0; head = 0; count = 0; scroll_sum = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(99) < 90) return $urandom_range(2);
    return $urandom_range(40, 5);
  endfunction

  // Send one word and update the model when it is taken
  task automatic send_word(logic [2:0] m, logic [7:0] pid, logic signed [19:0] y,
                           logic [31:0] t);
    int g;
    g = gaps_on ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m; pointer_id <= pid; pos_y <= y; time_ms <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_word(m, pid, y, t);
  endtask

  // Drop valid once the stream pauses
  task automatic end_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_decel(logic [15:0] v);
    end_stream();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_DECEL; pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    decel = v;
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result delta=%0d vel=%0d fling=%0d", $time,
                 scroll_delta, velocity, fling_distance);
        errors++;
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (e.delta !== scroll_delta) begin
          $display("%0t: scroll_delta exp %0d got %0d", $time, e.delta, scroll_delta);
          errors++;
        end
        if (e.vel !== velocity) begin
          $display("%0t: velocity exp %0d got %0d", $time, e.vel, velocity);
          errors++;
        end
        if (e.fling !== fling_distance) begin
          $display("%0t: fling_distance exp %0d got %0d", $time, e.fling,
                   fling_distance);
          errors++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_rx) out_stall <= 1'b1;
    else if (!gaps_on) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= ($urandom_range(3) == 0) ? gap_len() : 0;
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] tick(int lo, int hi);
    now_ms += $urandom_range(hi, lo);
    return now_ms;
  endfunction

  function automatic logic signed [19:0] step_y();
    cur_y = cur_y + $signed(20'($urandom_range(2000))) - 20'sd1000;
    return cur_y;
  endfunction

  task automatic test_directed();
    send_word(MODE_QUERY, 8'd0, 20'sd0, 32'd0);
    send_word(MODE_DOWN, 8'hff, 20'sh80000, 32'hfffffff0);
    send_word(MODE_MOVE, 8'hff, 20'sh7ffff, 32'hfffffff8);
    send_word(MODE_MOVE, 8'h00, 20'sd5, 32'd0);
    send_word(MODE_MOVE, 8'hff, 20'sh7ffff, 32'h00000002);
    send_word(MODE_MOVE, 8'hff, 20'sh80000, 32'h00000002);
    send_word(MODE_MOVE, 8'hff, 20'sd100, 32'h00000001);
    send_word(MODE_QUERY, 8'd0, 20'sd0, 32'd0);
    send_word(MODE_UP, 8'hff, 20'sd0, 32'd10);
    send_word(MODE_MOVE, 8'hff, 20'sd77, 32'd12);
    send_word(MODE_QUERY, 8'd0, 20'sd0, 32'd0);
    send_word(3'd6, 8'd1, 20'sd1, 32'd1);
    send_word(3'd7, 8'd1, 20'sd1, 32'd1);
    send_word(MODE_DOWN, 8'd9, 20'sd0, 32'd100);
    send_word(MODE_QUERY, 8'd0, 20'sd0, 32'd0);
    send_word(MODE_CANCEL, 8'd9, 20'sd0, 32'd0);
    send_word(MODE_QUERY, 8'd0, 20'sd0, 32'd0);
    send_word(MODE_RESET, 8'd0, 20'sd0, 32'd0);
    send_word(MODE_QUERY, 8'd0, 20'sd0, 32'd0);
    // full-scale alternating jumps through the scroll sum
    send_word(MODE_DOWN, 8'd1, 20'sh80000, 32'd0);
    for (int i = 0; i < 4; i++) send_word(MODE_MOVE, 8'd1,
      (i % 2) ? 20'sh80000 : 20'sh7ffff, 32'd1 + i);
    send_word(MODE_QUERY, 8'd0, 20'sd0, 32'd0);
  endtask

  // A gesture: down, moves, occasional queries, then up, cancel, reset or nothing
  task automatic test_random_gestures(int words);
    int sent = 0;
    int nmove;
    while (sent < words) begin
      if ($urandom_range(9) == 0) begin
        send_word(3'($urandom_range(7)), 8'($urandom), 20'($urandom), $urandom);
        sent++;
        continue;
      end
      cur_ptr = ($urandom_range(3) == 0) ? 8'($urandom) : 8'd3;
      cur_y = 20'($urandom);
      send_word(MODE_DOWN, cur_ptr, cur_y, tick(0, 5));
      nmove = $urandom_range(24, 1);
      sent++;
      for (int i = 0; i < nmove; i++) begin
        case ($urandom_range(19))
          0: send_word(MODE_MOVE, cur_ptr ^ 8'h1, step_y(), tick(1, 20));
          1: send_word(MODE_MOVE, cur_ptr, 20'($urandom), $urandom);
          2: send_word(MODE_MOVE, cur_ptr, step_y(), now_ms - $urandom_range(5));
          3, 4: send_word(MODE_QUERY, 8'($urandom), 20'($urandom), $urandom);
          default: send_word(MODE_MOVE, cur_ptr, step_y(), tick(1, 30));
        endcase
        sent++;
      end
      send_word(MODE_QUERY, 8'd0, 20'sd0, 32'd0);
      case ($urandom_range(3))
        0: send_word(MODE_UP, cur_ptr, 20'($urandom), tick(0, 9));
        1: send_word(MODE_CANCEL, cur_ptr, 20'($urandom), tick(0, 9));
        2: send_word(MODE_RESET, 8'($urandom), 20'($urandom), $urandom);
        default: ;
      endcase
      if ($urandom_range(1)) send_word(MODE_QUERY, 8'd0, 20'sd0, 32'd0);
      sent += 3;
    end
  endtask

  // Receiver holds off while queries keep coming
  task automatic test_backpressure();
    int cnt;
    hold_rx = 1'b1;
    fork
      begin
        cnt = 0;
        while (cnt < 3000) begin
          @(posedge clk);
          cnt++;
        end
        hold_rx = 1'b0;
      end
      begin
        send_word(MODE_DOWN, 8'd4, 20'sd0, 32'd0);
        for (int i = 1; i < 8; i++) send_word(MODE_MOVE, 8'd4, 20'sd320 * i, 32'd16 * i);
        for (int i = 0; i < 6; i++) send_word(MODE_QUERY, 8'd0, 20'sd0, 32'd0);
        end_stream();
      end
    join
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      y_hist[i] = '0; t_hist[i] = '0;
    end
    head = 0; count = 0; active = 0; owner = 0; scroll_sum = 0; decel = DECEL_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_decel(16'd0);
    test_random_gestures(200);
    write_decel(16'd1);
    test_random_gestures(200);
    write_decel(16'hffff);
    test_random_gestures(200);
    write_decel(16'd500);
    gaps_on = 1'b0;
    test_random_gestures(150);
    gaps_on = 1'b1;
    test_backpressure();
    write_decel(16'($urandom));
    test_random_gestures(580);
    end_stream();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
